FILE: src/urm_pkg.sv
// Shared types and codes for the 16550-style register model.
`default_nettype none
package urm_pkg;

  localparam int InTdataW  = 24;
  localparam int OutTdataW = 24;
  localparam int ItemW     = 22;
  localparam int ResultW   = 19;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_BREAK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ADDR_RBR = 3'd0,
    ADDR_IER = 3'd1,
    ADDR_IIR = 3'd2,
    ADDR_LCR = 3'd3,
    ADDR_MCR = 3'd4,
    ADDR_LSR = 3'd5,
    ADDR_MSR = 3'd6,
    ADDR_SCR = 3'd7
  } addr_t;

  localparam logic [7:0] IIR_NONE  = 8'h01;
  localparam logic [7:0] IIR_TXE   = 8'h02;
  localparam logic [7:0] IIR_RXD   = 8'h04;
  localparam logic [7:0] LSR_IDLE  = 8'h60;
  localparam logic [7:0] LSR_DR    = 8'h01;
  localparam logic [7:0] MSR_VALUE = 8'hb0;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_CTRLC  = 8'h03;

  // packed high to low: first field ends up in the highest bits
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_present;
    logic [7:0] write_data;
    logic [2:0] address;
    logic [1:0] operation;
  } item_t;

  typedef struct packed {
    logic       irq_pending;
    logic       rx_taken;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } result_t;

endpackage
`default_nettype wire

FILE: src/urm_regfile.sv
// Register state and single-pass access logic of the UART model.
`default_nettype none
module urm_regfile (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire urm_pkg::item_t  item,
  output urm_pkg::result_t     result
);
  import urm_pkg::*;

  logic [7:0] divisor_low, divisor_low_next;
  logic [7:0] divisor_high, divisor_high_next;
  logic [7:0] int_enable, int_enable_next;
  logic [7:0] int_ident, int_ident_next;
  logic [7:0] line_ctl, line_ctl_next;
  logic [7:0] modem_ctl, modem_ctl_next;
  logic [7:0] scratch_reg, scratch_reg_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       rx_full, rx_full_next;
  logic       break_pending, break_pending_next;

  logic       dlab;
  logic       do_fill;
  logic [7:0] ier_eff;
  logic [7:0] xlat1;
  logic [7:0] xlat2;
  logic [7:0] rd;
  logic       txv;
  logic       taken;

  assign dlab  = line_ctl[7];
  assign xlat1 = (rx_hold == CH_LF) ? CH_CR : rx_hold;
  assign xlat2 = (xlat1 == CH_DEL) ? CH_BS : xlat1;

  always_comb begin
    divisor_low_next   = divisor_low;
    divisor_high_next  = divisor_high;
    int_enable_next    = int_enable;
    int_ident_next     = int_ident;
    line_ctl_next      = line_ctl;
    modem_ctl_next     = modem_ctl;
    scratch_reg_next   = scratch_reg;
    rx_hold_next       = rx_hold;
    rx_full_next       = rx_full;
    break_pending_next = break_pending;
    rd      = 8'h00;
    txv     = 1'b0;
    taken   = 1'b0;
    do_fill = 1'b0;
    ier_eff = int_enable;
    case (item.operation)
      OP_READ: begin
        case (item.address)
          ADDR_RBR: begin
            if (dlab) begin
              rd = divisor_low;
            end else begin
              rx_full_next = 1'b0;
              rx_hold_next = xlat2;
              rd           = xlat2;
            end
          end
          ADDR_IER: rd = dlab ? divisor_high : int_enable;
          ADDR_IIR: begin
            rd             = int_ident;
            int_ident_next = IIR_NONE;
          end
          ADDR_LCR: rd = line_ctl;
          ADDR_MCR: rd = modem_ctl;
          ADDR_LSR: do_fill = 1'b1;
          ADDR_MSR: rd = MSR_VALUE;
          default:  rd = scratch_reg;
        endcase
      end
      OP_WRITE: begin
        case (item.address)
          ADDR_RBR: begin
            if (dlab) begin
              divisor_low_next = item.write_data;
            end else begin
              txv = 1'b1;
              if (int_enable[1] && int_ident == IIR_NONE) begin
                int_ident_next = IIR_TXE;
              end
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              divisor_high_next = item.write_data;
            end else begin
              int_enable_next = item.write_data;
              ier_eff         = item.write_data;
              do_fill         = 1'b1;
            end
          end
          ADDR_LCR: line_ctl_next    = item.write_data;
          ADDR_MCR: modem_ctl_next   = item.write_data;
          ADDR_SCR: scratch_reg_next = item.write_data;
          default: ;
        endcase
      end
      OP_BREAK: break_pending_next = 1'b1;
      default: ;
    endcase

    // line status fill; reached only from LSR read or IER write
    if (do_fill) begin
      if (!rx_full) begin
        if (break_pending) begin
          rx_full_next       = 1'b1;
          rx_hold_next       = CH_CTRLC;
          break_pending_next = 1'b0;
        end else if (item.rx_present) begin
          rx_full_next = 1'b1;
          rx_hold_next = item.rx_byte;
          taken        = 1'b1;
        end
      end
      if (rx_full_next) begin
        if (ier_eff[0]) begin
          int_ident_next = IIR_RXD;
        end
        if (item.operation == OP_READ) begin
          rd = LSR_IDLE | LSR_DR;
        end
      end else if (item.operation == OP_READ) begin
        rd = LSR_IDLE;
      end
    end
  end

  always_comb begin
    result.read_data   = rd;
    result.tx_valid    = txv;
    result.tx_byte     = txv ? item.write_data : 8'h00;
    result.rx_taken    = taken;
    result.irq_pending = (int_ident_next != IIR_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_low   <= 8'h00;
      divisor_high  <= 8'h00;
      int_enable    <= 8'h00;
      int_ident     <= IIR_NONE;
      line_ctl      <= 8'h00;
      modem_ctl     <= 8'h00;
      scratch_reg   <= 8'h00;
      rx_hold       <= 8'h00;
      rx_full       <= 1'b0;
      break_pending <= 1'b0;
    end else if (advance) begin
      divisor_low   <= divisor_low_next;
      divisor_high  <= divisor_high_next;
      int_enable    <= int_enable_next;
      int_ident     <= int_ident_next;
      line_ctl      <= line_ctl_next;
      modem_ctl     <= modem_ctl_next;
      scratch_reg   <= scratch_reg_next;
      rx_hold       <= rx_hold_next;
      rx_full       <= rx_full_next;
      break_pending <= break_pending_next;
    end
  end

  a_taken_fills: assert property (@(posedge clk) disable iff (rst)
    advance && result.rx_taken |=> rx_full && rx_hold == $past(item.rx_byte))
    else $error("taken byte not held");

  a_iir_read_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.operation == OP_READ && item.address == ADDR_IIR |=> int_ident == IIR_NONE)
    else $error("IIR read did not clear identity");

  a_tx_only_thr: assert property (@(posedge clk) disable iff (rst)
    advance && result.tx_valid |-> item.operation == OP_WRITE && item.address == ADDR_RBR && !dlab)
    else $error("transmit outside THR write");

  a_irq_tracks: assert property (@(posedge clk) disable iff (rst)
    advance |=> $past(result.irq_pending) == (int_ident != IIR_NONE))
    else $error("irq flag disagrees with identity");

endmodule
`default_nettype wire

FILE: src/uart_16550_register_model_unit.sv
// Top level: input register, register file pass and output register.
// An accepted transfer is held in the input register, and its result in the output register.
// One transfer per cycle while the output is not stalled, set by the single-pass regfile update.
// Backpressure on the output stalls the input register and the regfile update, one deep per side.
// Reset (rst, synchronous, active high) clears both stage valids and all UART
// registers; IIR resets to the no-interrupt code.
`default_nettype none
module uart_16550_register_model_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // operation[1:0] address[4:2] write_data[12:5] rx_present[13] rx_byte[21:14]
  input  wire logic [urm_pkg::InTdataW-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // read_data[7:0] tx_valid[8] tx_byte[16:9] rx_taken[17] irq_pending[18]
  output logic [urm_pkg::OutTdataW-1:0]        m_tdata
);
  import urm_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t result;
  result_t out_result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= item_t'(s_tdata[ItemW-1:0]);
    end
  end

  urm_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OutTdataW - ResultW){1'b0}}, out_result};

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Stream testbench for the 16550-style register model: random and directed bus accesses.
module tb_top;
  import urm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 100000;
  localparam int DlabBit    = 7;
  localparam int HoldCycles = 120;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_tdata;

  uart_16550_register_model_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  item_t   pending_accesses[$];
  result_t expected_results[$];
  int      accesses_queued = 0;
  int      accesses_taken = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 35;
  int      recv_idle_pct = 35;
  bit      s_accepted = 1'b0;
  bit      hold_trigger = 1'b0;
  bit      hold_seen = 1'b0;
  int      hold_left = 0;

  // register file copy
  logic [7:0] div_lo = '0, div_hi = '0, int_enable = '0, int_ident = IIR_NONE;
  logic [7:0] line_ctl = '0, modem_ctl = '0, scratch = '0, rx_hold = '0;
  logic       rx_full = 1'b0, break_pending = 1'b0;

  function automatic logic [7:0] fill_rx_holder(input logic present, input logic [7:0] rx_in,
                                                output logic taken);
    taken = 1'b0;
    if (!rx_full) begin
      if (break_pending) begin
        rx_full = 1'b1;
        rx_hold = CH_CTRLC;
        break_pending = 1'b0;
      end else if (present) begin
        rx_full = 1'b1;
        rx_hold = rx_in;
        taken = 1'b1;
      end
    end
    if (rx_full) begin
      if (int_enable[0]) int_ident = IIR_RXD;
      return LSR_IDLE | LSR_DR;
    end
    return LSR_IDLE;
  endfunction

  function automatic result_t uart_regs_step(input item_t acc);
    result_t r;
    logic    dlab;
    logic    taken;
    r = '0;
    taken = 1'b0;
    dlab = line_ctl[DlabBit];
    case (acc.operation)
      OP_READ: begin
        case (acc.address)
          ADDR_RBR: begin
            if (dlab) begin
              r.read_data = div_lo;
            end else begin
              rx_full = 1'b0;
              if (rx_hold == CH_LF) rx_hold = CH_CR;
              if (rx_hold == CH_DEL) rx_hold = CH_BS;
              r.read_data = rx_hold;
            end
          end
          ADDR_IER: r.read_data = dlab ? div_hi : int_enable;
          ADDR_IIR: begin
            r.read_data = int_ident;
            int_ident = IIR_NONE;
          end
          ADDR_LCR: r.read_data = line_ctl;
          ADDR_MCR: r.read_data = modem_ctl;
          ADDR_LSR: r.read_data = fill_rx_holder(acc.rx_present, acc.rx_byte, taken);
          ADDR_MSR: r.read_data = MSR_VALUE;
          default:  r.read_data = scratch;
        endcase
      end
      OP_WRITE: begin
        case (acc.address)
          ADDR_RBR: begin
            if (dlab) begin
              div_lo = acc.write_data;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = acc.write_data;
              if (int_enable[1] && int_ident == IIR_NONE) int_ident = IIR_TXE;
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              div_hi = acc.write_data;
            end else begin
              int_enable = acc.write_data;
              void'(fill_rx_holder(acc.rx_present, acc.rx_byte, taken));
            end
          end
          ADDR_LCR: line_ctl = acc.write_data;
          ADDR_MCR: modem_ctl = acc.write_data;
          ADDR_SCR: scratch = acc.write_data;
          default: ;
        endcase
      end
      OP_BREAK: break_pending = 1'b1;
      default: ;
    endcase
    r.rx_taken = taken;
    r.irq_pending = (int_ident != IIR_NONE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send_access(input logic [1:0] op, input logic [2:0] addr,
                             input logic [7:0] wdata, input logic present,
                             input logic [7:0] rx_in);
    item_t acc;
    acc.operation = op_t'(op);
    acc.address = addr_t'(addr);
    acc.write_data = wdata;
    acc.rx_present = present;
    acc.rx_byte = rx_in;
    pending_accesses.push_back(acc);
    accesses_queued++;
  endtask

  function automatic logic [7:0] pick_rx_byte();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return CH_LF;
    if (sel == 1) return CH_DEL;
    return 8'($urandom);
  endfunction

  task automatic queue_random_accesses(input int count);
    int         n;
    int         sel;
    logic [7:0] wdata;
    logic [2:0] addr;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        // status poll then receive buffer read
        send_access(OP_READ, ADDR_LSR, 8'($urandom), 1'($urandom), pick_rx_byte());
        send_access(OP_READ, ADDR_RBR, 8'($urandom), 1'($urandom), pick_rx_byte());
        n += 2;
      end else begin
        addr = 3'($urandom);
        wdata = 8'($urandom);
        if (addr == ADDR_LCR && $urandom_range(99) < 60) wdata[DlabBit] = 1'b0;
        if (sel < 62) send_access(OP_READ, addr, wdata, 1'($urandom), pick_rx_byte());
        else if (sel < 90) send_access(OP_WRITE, addr, wdata, 1'($urandom), pick_rx_byte());
        else if (sel < 96) send_access(OP_BREAK, addr, wdata, 1'($urandom), pick_rx_byte());
        else send_access(2'd3, addr, wdata, 1'($urandom), pick_rx_byte());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (accesses_taken != accesses_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_accepted) begin
      if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata <= InTdataW'(pending_accesses.pop_front());
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // input and result transfers
  always @(posedge clk) begin
    result_t got;
    result_t want;
    s_accepted = !rst && s_tvalid && s_tready;
    if (s_accepted) begin
      expected_results.push_back(uart_regs_step(item_t'(s_tdata[ItemW-1:0])));
      accesses_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[ResultW-1:0]);
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: 0x%05h", got);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("rx_taken", 8'(want.rx_taken), 8'(got.rx_taken));
        check_field("irq_pending", 8'(want.irq_pending), 8'(got.irq_pending));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("uart_16550_register_model_unit test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send_access(OP_READ, ADDR_LSR, 8'h00, 1'b0, 8'hff);
    send_access(OP_READ, ADDR_RBR, 8'hff, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_IER, 8'h03, 1'b1, CH_LF);
    send_access(OP_READ, ADDR_IIR, 8'h00, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_RBR, 8'h00, 1'b1, 8'h00);
    send_access(OP_READ, ADDR_RBR, 8'h00, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_RBR, 8'h41, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_IIR, 8'h00, 1'b0, 8'h00);
    send_access(OP_BREAK, ADDR_SCR, 8'hff, 1'b1, 8'hff);
    send_access(OP_READ, ADDR_LSR, 8'h00, 1'b1, 8'h55);
    send_access(OP_READ, ADDR_RBR, 8'h00, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_LSR, 8'h00, 1'b1, CH_DEL);
    send_access(OP_READ, ADDR_RBR, 8'h00, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_LCR, 8'h80, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_RBR, 8'hff, 1'b1, 8'hff);
    send_access(OP_WRITE, ADDR_IER, 8'ha5, 1'b1, 8'h12);
    send_access(OP_READ, ADDR_RBR, 8'h00, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_IER, 8'h00, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_LCR, 8'h03, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_MCR, 8'hff, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_SCR, 8'h5a, 1'b0, 8'h00);
    send_access(OP_WRITE, ADDR_IIR, 8'hff, 1'b1, 8'h77);
    send_access(OP_WRITE, ADDR_LSR, 8'hff, 1'b1, 8'h77);
    send_access(OP_WRITE, ADDR_MSR, 8'hff, 1'b1, 8'h77);
    send_access(2'd3, ADDR_SCR, 8'hff, 1'b1, 8'hff);
    send_access(OP_READ, ADDR_MCR, 8'h00, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_SCR, 8'h00, 1'b0, 8'h00);
    send_access(OP_READ, ADDR_MSR, 8'h00, 1'b0, 8'h00);
    wait_drained();

    queue_random_accesses(250);
    wait_drained();

    // back to back with a long output stall up front
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger = ~hold_trigger;
    queue_random_accesses(250);
    wait_drained();

    send_idle_pct = 35;
    recv_idle_pct = 35;
    queue_random_accesses(250);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("uart_16550_register_model_unit test passed");
    end else begin
      $display("uart_16550_register_model_unit test failed");
    end
    $finish;
  end

endmodule
